// File: rtl/cnfca_pkg.sv
`default_nettype none
package cnfca_pkg;
    localparam int CellsDefault = 64;
    localparam logic [6:0] BufSizeReset = 7'd64;
    localparam logic [7:0] ChA = 8'h41;
    localparam logic [7:0] ChZ = 8'h5A;
    localparam logic [7:0] Cha = 8'h61;
    localparam logic [7:0] Chz = 8'h7A;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StBadLen = 2'd1;
    localparam logic [1:0] StBadLab = 2'd2;
    localparam logic [1:0] StNoRun  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SRCH_RD,
        S_SRCH,
        S_CMP_RD,
        S_CMP,
        S_CMP_FILL,
        S_WRITE,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// File: rtl/cnfca_ram.sv
`default_nettype none
module cnfca_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/circular_next_fit_cell_allocator_core.sv
`default_nettype none
// Circular next-fit allocator over a store of byte cells kept in one
// synchronous RAM. An assign beat looks, starting at the remembered search
// position and wrapping past the last cell in use, for a run of free cells
// of the requested length and fills it with the (uppercased) label; a
// release beat looks for a run holding the label and frees it. If the scan
// fails, occupied cells are compacted stably to the front and the scan is
// repeated. Every step touches one cell per cycle through the single RAM
// port pair. Where n is the number of cells in use, a request is first
// accepted; a rejected request then goes straight to the result. Otherwise
// the first scan runs (a read setup step, then up to 2*n cells); if that
// scan fails, compaction follows (a read setup step, n cells read, then the
// tail cells cleared) and the scan is repeated; then the run of length
// cells is written and the result is shown. After reset a clearing pass
// writes zero to all CELLS entries, one per cycle, before the first beat
// is accepted. The result is held in an output register until taken; the
// next beat is accepted in the cycle after it has been taken.
module circular_next_fit_cell_allocator_core #(
    parameter int CELLS = cnfca_pkg::CellsDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [6:0]  i_cfg_wdata,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_op,
    input  wire  [6:0]  i_length,
    input  wire  [7:0]  i_label,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_position,
    output logic        o_compacted
);
    localparam int AW = $clog2(CELLS);
    // Counters hold up to twice the cell count and never less than a length.
    localparam int CW = (AW + 2 > 8) ? AW + 2 : 8;

    cnfca_pkg::t_state r_state, n_state;

    logic [6:0]    r_bufsize;
    logic [AW-1:0] r_sstart, n_sstart;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_len, n_len;
    logic [7:0]    r_want, n_want, r_fill, n_fill;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_s, n_s;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_packed, n_packed;
    logic [1:0]    r_status, n_status;
    logic [5:0]    r_pos, n_pos;
    logic [AW:0]   r_clr, n_clr;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    cnfca_ram #(.Width(8), .Depth(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // Clamped size in use.
    logic [CW-1:0] nuse;
    always_comb begin
        if (r_bufsize == 7'd0) nuse = CW'(1);
        else if ({{(CW-7){1'b0}}, r_bufsize} > CW'(CELLS)) nuse = CW'(CELLS);
        else nuse = CW'(r_bufsize);
    end

    logic [7:0] lab_f;
    logic       lab_ok;
    logic [CW-1:0] in_len;
    always_comb begin
        lab_f = i_label;
        if (!i_op && i_label >= cnfca_pkg::Cha && i_label <= cnfca_pkg::Chz)
            lab_f = i_label - 8'h20;
        lab_ok = lab_f >= cnfca_pkg::ChA && lab_f <= cnfca_pkg::ChZ;
        in_len = CW'(i_length);
    end

    // Helper values for scan.
    logic [AW-1:0] idx_inc;
    logic [CW-1:0] cnt_inc;
    always_comb begin
        idx_inc = (CW'(r_idx) + CW'(1) < r_n) ? r_idx + AW'(1) : '0;
        cnt_inc = r_cnt + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bufsize <= cnfca_pkg::BufSizeReset;
        end else if (i_cfg_we) begin
            r_bufsize <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cnfca_pkg::S_CLEAR;
            r_sstart <= '0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_sstart <= n_sstart;
            r_clr    <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_want   <= n_want;
        r_fill   <= n_fill;
        r_k      <= n_k;
        r_s      <= n_s;
        r_cnt    <= n_cnt;
        r_head   <= n_head;
        r_idx    <= n_idx;
        r_wp     <= n_wp;
        r_packed <= n_packed;
        r_status <= n_status;
        r_pos    <= n_pos;
        if (r_state == cnfca_pkg::S_IDLE) r_n <= nuse;
    end

    always_comb begin
        n_state  = r_state;
        n_sstart = r_sstart;
        n_clr    = r_clr;
        n_len    = r_len;
        n_want   = r_want;
        n_fill   = r_fill;
        n_k      = r_k;
        n_s      = r_s;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_idx    = r_idx;
        n_wp     = r_wp;
        n_packed = r_packed;
        n_status = r_status;
        n_pos    = r_pos;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = 8'd0;
        raddr    = r_idx;
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        unique case (r_state)
            cnfca_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr[AW-1:0];
                n_clr = r_clr + (AW+1)'(1);
                if (r_clr == (AW+1)'(CELLS - 1)) n_state = cnfca_pkg::S_IDLE;
            end
            cnfca_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_len    = in_len;
                    n_want   = i_op ? lab_f : 8'd0;
                    n_fill   = i_op ? 8'd0 : lab_f;
                    n_packed = 1'b0;
                    n_pos    = '0;
                    if (i_length == 7'd0 || in_len > nuse) begin
                        n_status = cnfca_pkg::StBadLen;
                        n_state  = cnfca_pkg::S_DONE;
                    end else if (!lab_ok) begin
                        n_status = cnfca_pkg::StBadLab;
                        n_state  = cnfca_pkg::S_DONE;
                    end else begin
                        n_status = cnfca_pkg::StOk;
                        n_state  = cnfca_pkg::S_SRCH_RD;
                        n_s      = (CW'(r_sstart) < nuse) ? CW'(r_sstart) : '0;
                    end
                end
            end
            cnfca_pkg::S_SRCH_RD: begin
                n_idx   = r_s[AW-1:0];
                n_head  = r_s[AW-1:0];
                n_k     = '0;
                n_cnt   = '0;
                raddr   = r_s[AW-1:0];
                n_state = cnfca_pkg::S_SRCH;
            end
            cnfca_pkg::S_SRCH: begin
                // rdata holds cell r_idx; prefetch the next cell.
                raddr = idx_inc;
                n_idx = idx_inc;
                n_k   = r_k + CW'(1);
                if (rdata == r_want) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_wp    = r_head;
                        n_pos   = 6'(r_head);
                        n_k     = '0;
                        n_state = cnfca_pkg::S_WRITE;
                    end
                end else begin
                    n_cnt  = '0;
                    n_head = idx_inc;
                end
                if (n_state == cnfca_pkg::S_SRCH) begin
                    if ((rdata != r_want && r_k >= r_n - r_s
                         && CW'(r_idx) == r_n - CW'(1))
                        || r_k + CW'(1) >= (r_n << 1) - r_s) begin
                        if (r_packed) begin
                            n_status = cnfca_pkg::StNoRun;
                            n_pos    = '0;
                            n_state  = cnfca_pkg::S_DONE;
                        end else begin
                            n_packed = 1'b1;
                            n_idx    = '0;
                            n_wp     = '0;
                            n_state  = cnfca_pkg::S_CMP_RD;
                        end
                    end
                end
            end
            cnfca_pkg::S_CMP_RD: begin
                raddr   = '0;
                n_idx   = '0;
                n_state = cnfca_pkg::S_CMP;
            end
            cnfca_pkg::S_CMP: begin
                // Write pointer never passes read pointer, so stable packing.
                raddr = r_idx + AW'(1);
                n_idx = r_idx + AW'(1);
                if (rdata != 8'd0) begin
                    we    = 1'b1;
                    waddr = r_wp;
                    wdata = rdata;
                    n_wp  = r_wp + AW'(1);
                end
                if (CW'(r_idx) == r_n - CW'(1)) begin
                    n_k     = (rdata != 8'd0) ? CW'(r_wp) + CW'(1) : CW'(r_wp);
                    n_state = cnfca_pkg::S_CMP_FILL;
                end
            end
            cnfca_pkg::S_CMP_FILL: begin
                if (r_k < r_n) begin
                    we    = 1'b1;
                    waddr = r_k[AW-1:0];
                    n_k   = r_k + CW'(1);
                end else begin
                    n_s      = (CW'(r_wp) < r_n && r_wp != '0) ? CW'(r_wp) : '0;
                    // Store full wraps wp to zero; also covers empty store.
                    n_sstart = n_s[AW-1:0];
                    n_state  = cnfca_pkg::S_SRCH_RD;
                end
            end
            cnfca_pkg::S_WRITE: begin
                we    = 1'b1;
                waddr = r_wp;
                wdata = r_fill;
                n_wp  = (CW'(r_wp) + CW'(1) < r_n) ? r_wp + AW'(1) : '0;
                n_k   = r_k + CW'(1);
                if (r_k + CW'(1) >= r_len) begin
                    n_sstart = r_head;
                    n_state  = cnfca_pkg::S_DONE;
                end
            end
            cnfca_pkg::S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) n_state = cnfca_pkg::S_IDLE;
            end
            default: n_state = cnfca_pkg::S_IDLE;
        endcase
    end

    assign o_status    = r_status;
    assign o_position  = r_pos;
    assign o_compacted = r_packed;

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_ok_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == cnfca_pkg::StBadLen) |-> !r_packed)
        else $error("compaction on bad length");
    a_norun_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == cnfca_pkg::StNoRun) |-> r_packed)
        else $error("no run without compaction");
endmodule
`default_nettype wire

// File: bench/circular_next_fit_cell_allocator_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps a private copy of the cell store, the search position
// and the size register, predicts the reply to every accepted request and
// compares replies against the oldest prediction.
class alloc_scoreboard;
    logic [7:0]  cells [64];
    int unsigned scan_from;
    logic [6:0]  size_reg;
    logic [1:0]  q_status [$];
    logic [5:0]  q_pos [$];
    logic        q_packed [$];
    int          errors;
    int          replies;
    int          compactions;
    int          ok_count;

    function new();
        foreach (cells[i]) cells[i] = 8'h00;
        scan_from = 0;
        size_reg = cnfca_pkg::BufSizeReset;
        errors = 0;
        replies = 0;
        compactions = 0;
        ok_count = 0;
    endfunction

    function int unsigned span();
        int unsigned n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function bit find_run(int unsigned n, int unsigned len, logic [7:0] want,
                          output int unsigned where);
        int unsigned s, total, count, head, idx;
        s = (scan_from < n) ? scan_from : 0;
        total = 2 * n - s;
        count = 0;
        head = s;
        where = 0;
        for (int unsigned k = 0; k < total; k++) begin
            idx = s + k;
            if (idx >= n) idx -= n;
            if (cells[idx] == want) begin
                count++;
            end else begin
                count = 0;
                head = (idx + 1 < n) ? idx + 1 : 0;
                // The second lap ends at the first blocked last cell.
                if (k >= n - s && idx == n - 1) return 0;
            end
            if (count >= len) begin
                where = head;
                return 1;
            end
        end
        return 0;
    endfunction

    function void squeeze(int unsigned n);
        int unsigned w;
        w = 0;
        for (int unsigned r = 0; r < n; r++) begin
            if (cells[r] != 8'h00) begin
                cells[w] = cells[r];
                w++;
            end
        end
        for (int unsigned r = w; r < n; r++) cells[r] = 8'h00;
        scan_from = (w < n) ? w : 0;
    endfunction

    function void note_request(logic op, logic [6:0] len, logic [7:0] lab);
        int unsigned n, at, idx;
        logic [7:0] want, fill;
        logic was_packed;
        n = span();
        was_packed = 1'b0;
        at = 0;
        if (len == 0 || len > n) begin
            push(cnfca_pkg::StBadLen, 6'd0, 1'b0);
            return;
        end
        // Only assigns fold lowercase letters.
        if (op == 1'b0 && lab >= cnfca_pkg::Cha && lab <= cnfca_pkg::Chz)
            lab = lab - (cnfca_pkg::Cha - cnfca_pkg::ChA);
        if (lab < cnfca_pkg::ChA || lab > cnfca_pkg::ChZ) begin
            push(cnfca_pkg::StBadLab, 6'd0, 1'b0);
            return;
        end
        want = op ? lab : 8'h00;
        fill = op ? 8'h00 : lab;
        if (!find_run(n, len, want, at)) begin
            squeeze(n);
            was_packed = 1'b1;
            compactions++;
            if (!find_run(n, len, want, at)) begin
                push(cnfca_pkg::StNoRun, 6'd0, 1'b1);
                return;
            end
        end
        for (int unsigned k = 0; k < len; k++) begin
            idx = at + k;
            if (idx >= n) idx -= n;
            cells[idx] = fill;
        end
        scan_from = at;
        ok_count++;
        push(cnfca_pkg::StOk, at[5:0], was_packed);
    endfunction

    function void push(logic [1:0] st, logic [5:0] p, logic c);
        q_status.push_back(st);
        q_pos.push_back(p);
        q_packed.push_back(c);
    endfunction

    function void check_reply(logic [1:0] st, logic [5:0] p, logic c);
        replies++;
        if (q_status.size() == 0) begin
            $error("unexpected reply: status %0d position %0d compacted %0d", st, p, c);
            errors++;
            return;
        end
        if (st !== q_status[0]) begin
            $error("status: expected %0d actual %0d", q_status[0], st);
            errors++;
        end
        if (p !== q_pos[0]) begin
            $error("position: expected %0d actual %0d", q_pos[0], p);
            errors++;
        end
        if (c !== q_packed[0]) begin
            $error("compacted: expected %0d actual %0d", q_packed[0], c);
            errors++;
        end
        void'(q_status.pop_front());
        void'(q_pos.pop_front());
        void'(q_packed.pop_front());
    endfunction

    function int pending();
        return q_status.size();
    endfunction
endclass

module circular_next_fit_cell_allocator_core_tb;
    // The limit covers the longest request plus a long receiver stall,
    // and the clearing pass after reset.
    localparam int WatchdogLimit = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_wdata = '0;
    logic       i_valid = 1'b0;
    logic       i_op = 1'b0;
    logic [6:0] i_length = '0;
    logic [7:0] i_label = '0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_status;
    logic [5:0] o_position;
    logic       o_compacted;

    // Percent chance per cycle that the sender idles and the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned idle_cycles = 0;
    int          sent = 0;

    alloc_scoreboard board = new();

    always #4 i_clk = ~i_clk;

    circular_next_fit_cell_allocator_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_length(i_length),
        .i_label(i_label),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_position(o_position),
        .o_compacted(o_compacted)
    );

    // Result side: a reply beat is checked at the edge where it is taken,
    // and the receiver's ready is redrawn once per edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_reply(o_status, o_position, o_compacted);
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: counts edges at which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog expired with %0d replies pending", board.pending());
                $display("circular_next_fit_cell_allocator_core: mismatch");
                $finish;
            end
        end
    end

    // Drives one request beat and holds it until accepted; the prediction
    // is made at the accepting edge. Valid is dropped only while the sender
    // idles, so a following beat can go out back to back.
    task automatic send_request(logic op, logic [6:0] len, logic [7:0] lab);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_length <= len;
        i_label <= lab;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(op, len, lab);
        sent++;
    endtask

    // Waits for every reply, then a margin so the block is truly idle,
    // and writes the size register.
    task automatic set_size(logic [6:0] value);
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.size_reg = value;
    endtask

    // Random label: mostly letters from a small pool so releases find
    // matches; sometimes lowercase, sometimes any byte.
    function automatic logic [7:0] pick_label();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return cnfca_pkg::ChA + 8'($urandom_range(5));
        if (r < 85) return cnfca_pkg::Cha + 8'($urandom_range(5));
        if (r < 92) return cnfca_pkg::ChA + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    task automatic random_requests(int count);
        int unsigned n, len;
        for (int i = 0; i < count; i++) begin
            n = board.span();
            len = $urandom_range(99) < 6 ? $urandom_range(127)
                                         : 1 + $urandom_range((n > 8) ? 7 : n - 1);
            if ($urandom_range(99) < 3) len = n;
            send_request(1'($urandom_range(1)), len[6:0], pick_label());
        end
    endtask

    task automatic set_idling(int unsigned s, int unsigned r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset size of 64 cells.
        send_request(1'b0, 7'd0, "A");           // zero length
        send_request(1'b0, 7'd65, "A");          // longer than the store
        send_request(1'b0, 7'd127, "A");
        send_request(1'b0, 7'd3, 8'h40);         // just below 'A'
        send_request(1'b0, 7'd3, 8'h5B);         // just above 'Z'
        send_request(1'b0, 7'd3, 8'hFF);
        send_request(1'b0, 7'd3, 8'h00);
        send_request(1'b1, 7'd2, "a");           // release never folds
        send_request(1'b0, 7'd5, "a");           // folded to 'A'
        send_request(1'b0, 7'd7, "z");
        send_request(1'b0, 7'd4, "Z");
        send_request(1'b1, 7'd7, "Z");           // frees the z run
        send_request(1'b1, 7'd3, "Q");           // missing label, compacts
        send_request(1'b0, 7'd50, "B");          // fits in the space freed by compaction
        send_request(1'b0, 7'd64, "C");          // cannot fit
        send_request(1'b1, 7'd50, "B");
        send_request(1'b1, 7'd4, "Z");
        send_request(1'b1, 7'd5, "A");
        send_request(1'b0, 7'd64, "D");          // fills the whole store
        send_request(1'b0, 7'd1, "E");           // store full
        send_request(1'b1, 7'd64, "D");

        // Small store where the scan wraps past the last cell, then the edges.
        set_size(7'd5);
        send_request(1'b0, 7'd3, "F");
        send_request(1'b0, 7'd1, "G");
        send_request(1'b1, 7'd3, "F");
        send_request(1'b0, 7'd3, "H");           // reuses cells 0 to 2
        set_size(7'd0);                           // acts as one cell
        send_request(1'b0, 7'd1, "I");
        send_request(1'b0, 7'd2, "I");

        // Random part across sizes and idling phases.
        set_size(7'd64);  set_idling(0, 0);   random_requests(150);
        set_size(7'd127); set_idling(84, 0);  random_requests(100);
        set_size(7'd12);  set_idling(0, 84);  random_requests(120);
        set_size(7'd1);   set_idling(19, 19); random_requests(60);
        set_size(7'd2);   set_idling(0, 0);   random_requests(80);
        set_size(7'd33);  set_idling(19, 19); random_requests(150);
        set_size(7'd8);   set_idling(84, 84); random_requests(80);
        set_size(7'd64);  set_idling(0, 0);   random_requests(160);

        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d requests, checked %0d replies (%0d ok, %0d compactions)",
                 sent, board.replies, board.ok_count, board.compactions);
        $display("store sizes from 1 to 64 plus out-of-range values, four idling phases");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("circular_next_fit_cell_allocator_core: match");
        end else begin
            $display("circular_next_fit_cell_allocator_core: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
